FILE: rtl/signed_int_to_decimal_ascii_defines.svh
// assertion helpers for the integer to decimal text block
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define SITDA_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define SITDA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sitda_pkg.sv
package sitda_pkg;

    // field widths
    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;

    // decimal digit store
    localparam int DIGITS   = 10;
    localparam int NIBBLE_W = 4;
    localparam int BCD_W    = DIGITS * NIBBLE_W;
    localparam int NDIG_W   = $clog2(DIGITS + 1);
    localparam int ITER_W   = $clog2(VALUE_W);

    // character codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // digit adjust threshold and offset for shift-add-3
    localparam logic [NIBBLE_W-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [NIBBLE_W-1:0] ADJ_ADD   = 4'd3;

    typedef logic [BCD_W-1:0] t_bcd;

endpackage

FILE: rtl/sitda_dabble.sv
module sitda_dabble (
    input  sitda_pkg::t_bcd i_bcd,
    input  logic            i_bit,
    output sitda_pkg::t_bcd o_bcd
);
    import sitda_pkg::*;

    t_bcd w_adj;

    // add three to every digit of five or more, digits are independent
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (i_bcd[d*NIBBLE_W +: NIBBLE_W] >= ADJ_LIMIT) begin
                w_adj[d*NIBBLE_W +: NIBBLE_W] = i_bcd[d*NIBBLE_W +: NIBBLE_W] + ADJ_ADD;
            end else begin
                w_adj[d*NIBBLE_W +: NIBBLE_W] = i_bcd[d*NIBBLE_W +: NIBBLE_W];
            end
        end
    end

    // shift in the next binary bit
    assign o_bcd = {w_adj[BCD_W-2:0], i_bit};

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Input channel: i_valid / o_stall with i_value, a two's-complement integer.
// A beat is taken when i_valid is high and o_stall is low; o_stall is high
// from the accepting edge until the last character has been loaded into the
// output register.
// Output channel: o_valid / i_stall with o_character and o_last. One beat per
// character, most significant first, a leading '-' for negative values and
// o_last set on the final digit. Zero gives a single '0'.
// Timing: after acceptance a shift-add-3 unit converts the magnitude, one
// input bit per cycle. Leading zero digits are then dropped one per cycle,
// then one character leaves per cycle while the receiver does not stall.
// The output register holds its beat while i_stall is high; the sequencer
// waits, so no character is dropped. The last character may still wait in
// the output register while the next number is already being converted.
// Reset (synchronous, active low) returns to idle and empties the output.
module signed_int_to_decimal_ascii (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [sitda_pkg::VALUE_W-1:0]  i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [sitda_pkg::CHAR_W-1:0]   o_character,
    output logic                                  o_last
);
    import sitda_pkg::*;

    `include "signed_int_to_decimal_ascii_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_TRIM = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0]          r_state, n_state;
    logic [VALUE_W-1:0]  r_bin,   n_bin;
    t_bcd                r_bcd,   n_bcd;
    logic [ITER_W-1:0]   r_cnt,   n_cnt;
    logic [NDIG_W-1:0]   r_ndig,  n_ndig;
    logic                r_neg,   n_neg;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char,  n_char;
    logic                r_last,  n_last;

    logic [VALUE_W-1:0]  w_raw;
    logic [VALUE_W-1:0]  w_mag;
    t_bcd                w_step;
    logic [NIBBLE_W-1:0] w_top;
    logic                w_in_beat;
    logic                w_out_free;

    // shared shift-add-3 step
    sitda_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bit (r_bin[VALUE_W-1]),
        .o_bcd (w_step)
    );

    // magnitude, the most negative value maps to its unsigned magnitude
    assign w_raw = i_value;
    assign w_mag = w_raw[VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;

    assign w_top      = r_bcd[BCD_W-1 -: NIBBLE_W];
    assign o_stall    = (r_state != S_IDLE);
    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && i_stall;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_bin   = w_mag;
                    n_neg   = w_raw[VALUE_W-1];
                    n_bcd   = '0;
                    n_cnt   = ITER_W'(VALUE_W - 1);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = w_step;
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_ndig  = NDIG_W'(DIGITS);
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                // drop one leading zero digit per cycle, keep at least one
                if (w_top == '0 && r_ndig != NDIG_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_char = ASCII_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = ASCII_ZERO + CHAR_W'(w_top);
                        n_last = (r_ndig == NDIG_W'(1));
                        n_bcd  = {r_bcd[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                        n_ndig = r_ndig - 1'b1;
                        if (r_ndig == NDIG_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // checks on the sequencer
    `SITDA_CHECK_NEXT(a_start_conv, w_in_beat,
        r_state == S_CONV && r_cnt == ITER_W'(VALUE_W - 1),
        "accepted beat did not start the conversion")
    `SITDA_CHECK(a_digit_range, r_state == S_TRIM || r_state == S_EMIT,
        w_top <= 4'd9 && r_ndig != '0, "bad leading digit or digit count")
    `SITDA_CHECK(a_sign_not_last, o_valid && o_character == ASCII_MINUS,
        !o_last, "minus sign flagged as last character")

endmodule

FILE: dv/tb_signed_int_to_decimal_ascii.sv
module tb_signed_int_to_decimal_ascii;

    import sitda_pkg::*;

    localparam int          CLK_HALF      = 2;
    localparam int          RESET_CYCLES  = 9;
    localparam int          DIR_N         = 24;
    localparam int          RANDOM_ITEMS  = 206;
    localparam int          LONG_HOLD     = 300;
    localparam int          HOLD_AFTER    = 30;
    localparam int          PAUSE_AT      = 60;
    localparam int          QUIET_FIRST   = 100;
    localparam int          QUIET_LAST    = 140;
    localparam int          DRAIN_CYCLES  = 60;
    localparam int          MAX_REPORTS   = 10;
    localparam int          RUN_LIMIT     = 2_000_000;
    localparam int          MAX_CHARS     = DIGITS + 1;
    localparam logic [31:0] RADIX         = 32'd10;

    // one character beat as seen on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_beat;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic        [CHAR_W-1:0]   o_character;
    logic                       o_last;

    t_char_beat pending_chars[$];
    int         numbers_sent   = 0;
    int         negatives_sent = 0;
    int         longest_text   = 0;
    int         chars_checked  = 0;
    int         mismatches     = 0;

    // directed rows: an empty text means the predictor supplies the characters
    logic [VALUE_W-1:0] dir_value [DIR_N] = '{
        32'd0, 32'd1, 32'hFFFFFFFF, 32'd9, 32'd10, 32'hFFFFFFF6, 32'd99, 32'd100,
        32'd12345, 32'hFFFFFFF9, 32'd999999999, 32'd1000000000, 32'hC4653600,
        32'd2147483647, 32'h80000000, 32'h80000001, 32'd2147483646, 32'd1234567890,
        32'hB669FD2E, 32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF, 32'hFFFF0000,
        32'h00010000
    };
    string dir_text [DIR_N] = '{
        "0", "1", "-1", "", "", "", "", "",
        "", "", "", "1000000000", "",
        "2147483647", "-2147483648", "-2147483647", "", "",
        "", "", "", "", "",
        ""
    };

    signed_int_to_decimal_ascii u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #RUN_LIMIT;
        $display("timeout with %0d characters still pending", pending_chars.size());
        $display("tb_signed_int_to_decimal_ascii NOT OK");
        $finish;
    end

    // queue the decimal text of one number, sign first, last flag on final digit
    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] word);
        logic [VALUE_W-1:0]  mag;
        logic [NIBBLE_W-1:0] digit [DIGITS];
        int                  ndig;
        int                  nchar;
        t_char_beat          beat;
        mag   = word[VALUE_W-1] ? (32'd0 - word) : word;
        ndig  = 0;
        nchar = 0;
        do begin
            digit[ndig] = NIBBLE_W'(mag % RADIX);
            mag         = mag / RADIX;
            ndig++;
        end while (mag != 0 && ndig < DIGITS);
        if (word[VALUE_W-1]) begin
            beat.code = ASCII_MINUS;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
            nchar++;
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            beat.code = ASCII_ZERO + CHAR_W'(digit[i]);
            beat.last = (i == 0);
            pending_chars.push_back(beat);
            nchar++;
        end
        if (nchar > longest_text) longest_text = nchar;
    endfunction

    // queue a text typed into the directed table
    function automatic void queue_typed_text(input string text);
        t_char_beat beat;
        for (int i = 0; i < text.len(); i++) begin
            beat.code = text[i];
            beat.last = (i == text.len() - 1);
            pending_chars.push_back(beat);
        end
        if (text.len() > longest_text) longest_text = text.len();
    endfunction

    // random number drawn from one of several shapes
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] word;
        logic [VALUE_W-1:0] pow10;
        int unsigned        k;
        pow10 = 32'd1;
        k     = $urandom_range(0, DIGITS - 1);
        for (int i = 0; i < k; i++) pow10 = pow10 * RADIX;
        case ($urandom_range(0, 9))
            0, 1, 2: word = $urandom();
            3:       word = $urandom_range(0, 99);
            4:       word = pow10 + 32'($urandom_range(0, 2)) - 32'd1;
            5:       word = 32'h80000000 + 32'($urandom_range(0, 3));
            6:       word = 32'h7FFFFFFF - 32'($urandom_range(0, 3));
            default: word = 32'($urandom_range(0, 32'hFFFFFFFF)) % (pow10 * RADIX);
        endcase
        // random sign flip, except for the most negative value
        if ($urandom_range(0, 1) == 1 && word != 32'h80000000) word = 32'd0 - word;
        return word;
    endfunction

    // offer one number and hold it until taken
    task automatic send_value(input logic [VALUE_W-1:0] word, input string text);
        i_valid <= 1'b1;
        i_value <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (text.len() == 0) queue_decimal_text(word);
        else queue_typed_text(text);
        numbers_sent++;
        if (word[VALUE_W-1]) negatives_sent++;
    endtask

    // sender: reset, directed table, then random bursts
    initial begin : sender
        int burst_left;
        int gap;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_N + RANDOM_ITEMS; n++) begin
            // wait for every character before going on
            if (n == DIR_N + PAUSE_AT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_chars.size() != 0) @(posedge i_clk);
            end
            // burst and gap pacing, no gaps in the quiet stretch
            if (burst_left == 0) begin
                if (n >= DIR_N + QUIET_FIRST && n < DIR_N + QUIET_LAST) gap = 0;
                else if ($urandom_range(0, 3) == 0) gap = $urandom_range(20, 60);
                else gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 10);
            end
            if (n < DIR_N) send_value(dir_value[n], dir_text[n]);
            else send_value(random_value(), "");
            burst_left--;
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        // drain and settle
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d numbers (%0d negative, longest text %0d of %0d characters)",
                 numbers_sent, negatives_sent, longest_text, MAX_CHARS);
        $display("checked %0d characters, %0d mismatches", chars_checked, mismatches);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("tb_signed_int_to_decimal_ascii OK");
        end else begin
            $display("tb_signed_int_to_decimal_ascii NOT OK");
        end
        $finish;
    end

    // receiver: random stall patterns, one long hold early on
    initial begin : receiver
        int          cyc;
        int unsigned mode;
        logic        held;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && numbers_sent >= HOLD_AFTER) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= cyc[0];
                endcase
                cyc++;
            end
        end
    end

    // mismatch reporting, first few in full
    task automatic note_mismatch(input string what, input t_char_beat want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch (%s): expected char %0d last %0b, got char %0d last %0b",
                     what, want.code, want.last, o_character, o_last);
        end
    endtask

    // output checker, one beat per accepted character
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                want = '0;
                note_mismatch("no character pending", want);
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.code || o_last !== want.last) begin
                    note_mismatch("wrong field", want);
                end
            end
        end
    end

endmodule
